// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks shared by the matrix multiply modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)

`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// File: hdl/dmm_pkg.sv
// ----------------------------------------------------------------------------
// dmm_pkg
// types and constants of the dense matrix multiply core
// ----------------------------------------------------------------------------
package dmm_pkg;

  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 6;
  localparam int DEPTH     = 64;
  localparam int DIM_W     = 4;
  localparam int POS_W     = 3;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 64;
  localparam int ACC_W     = 72;

  localparam logic [CNT_W-1:0] MAX_RESULTS = 7'd64;

  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_INNER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS  = 2'd3;

  typedef struct packed {
    logic [1:0]               func;
    logic [ADDR_W-1:0]        elem_index;
    logic signed [DATA_W-1:0] elem_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] prod_value;
    logic [POS_W-1:0]         out_row;
    logic [POS_W-1:0]         out_col;
    logic                     last;
    logic                     size_mismatch;
  } out_t;

  typedef struct packed {
    logic issue;
    logic first;
    logic last;
  } mac_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_ERR
  } seq_state_t;

endpackage

// File: hdl/dmm_store.sv
// ----------------------------------------------------------------------------
// dmm_store
// element memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module dmm_store (
  input  logic                             clk,
  input  logic                             we,
  input  logic [dmm_pkg::ADDR_W-1:0]       waddr,
  input  logic [dmm_pkg::DATA_W-1:0]       wdata,
  input  logic [dmm_pkg::ADDR_W-1:0]       raddr,
  output logic [dmm_pkg::DATA_W-1:0]       rdata
);

  logic [dmm_pkg::DATA_W-1:0] mem [dmm_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/dmm_mac.sv
// ----------------------------------------------------------------------------
// dmm_mac
// multiply-accumulate of one C entry, floor scaling and saturation
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmm_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dmm_pkg::mac_ctl_t                 ctl,
  input  logic signed [dmm_pkg::DATA_W-1:0] a_data,
  input  logic signed [dmm_pkg::DATA_W-1:0] b_data,
  input  logic                              take,
  output logic                              res_valid,
  output logic signed [dmm_pkg::DATA_W-1:0] res_value
);

  localparam int ACC_W  = dmm_pkg::ACC_W;
  localparam int PROD_W = dmm_pkg::PROD_W;
  localparam int DATA_W = dmm_pkg::DATA_W;

  logic                     m_v, m_first, m_last;
  logic                     p_v, p_first, p_last;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [ACC_W-1:0]  shifted;
  logic                     fits;

  // memory data arrives in the cycle after the read is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
      p_v <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      m_v <= ctl.issue;
      p_v <= m_v;
      if (p_v && p_last) begin
        res_valid <= 1'b1;
      end else if (take) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    m_first <= ctl.first;
    m_last  <= ctl.last;
    p_first <= m_first;
    p_last  <= m_last;
    if (m_v) begin
      prod <= a_data * b_data;
    end
    if (p_v) begin
      acc <= acc_next;
    end
  end

  always_comb begin
    acc_next = (p_first ? '0 : acc) + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  end

  assign shifted = acc >>> FRAC_BITS;
  assign fits = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);

  always_comb begin
    if (fits) begin
      res_value = shifted[DATA_W-1:0];
    end else if (acc[ACC_W-1]) begin
      res_value = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res_value = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  `ASSERT_NEVER(a_issue_while_held, res_valid && (m_v || p_v), "new term while result held")
  `ASSERT_CLK(a_last_sets_result, p_v && p_last |=> res_valid, "last term gave no result")
  `ASSERT_CLK(a_result_holds, res_valid && !take |=> res_valid, "result dropped before take")

endmodule

// File: hdl/dmm_ctrl.sv
// ----------------------------------------------------------------------------
// dmm_ctrl
// configuration registers, load path, entry sequencer and output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmm_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dmm_pkg::in_t                        in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dmm_pkg::out_t                       out_item,
  input  logic                                cfg_we,
  input  logic [dmm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dmm_pkg::DIM_W-1:0]           cfg_data,
  output logic                                a_we,
  output logic                                b_we,
  output logic [dmm_pkg::ADDR_W-1:0]          a_raddr,
  output logic [dmm_pkg::ADDR_W-1:0]          b_raddr,
  output dmm_pkg::mac_ctl_t                   mac_ctl,
  output logic                                take,
  input  logic                                res_valid,
  input  logic signed [dmm_pkg::DATA_W-1:0]   res_value
);

  localparam int DIM_W  = dmm_pkg::DIM_W;
  localparam int ADDR_W = dmm_pkg::ADDR_W;
  localparam int CNT_W  = dmm_pkg::CNT_W;
  localparam int POS_W  = dmm_pkg::POS_W;
  localparam logic [DIM_W-1:0] DIM_CAP =
    (MAX_DIM >= (1 << DIM_W) - 1) ? {DIM_W{1'b1}} : DIM_W'(MAX_DIM);
  localparam logic [2*DIM_W-1:0] RESULT_CAP = (2*DIM_W)'(dmm_pkg::MAX_RESULTS);

  dmm_pkg::seq_state_t state, state_next;

  logic [DIM_W-1:0]  a_rows, a_inner, b_rows, b_cols;
  logic [DIM_W-1:0]  kdim, cols;
  logic [DIM_W-1:0]  r, s, k;
  logic [ADDR_W-1:0] a_base;
  logic [CNT_W-1:0]  n, total;
  logic [2*DIM_W-1:0] size_prod;
  logic              slot_free;
  logic              accept;
  logic              emit, emit_err, start_ok;
  logic              entry_last;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] e;
    if (d == '0) begin
      e = DIM_W'(1);
    end else if (d > DIM_CAP) begin
      e = DIM_CAP;
    end else begin
      e = d;
    end
    return e;
  endfunction

  assign accept     = in_valid && !in_stall;
  assign a_we       = accept && (in_item.func == dmm_pkg::FUNC_LOAD_A);
  assign b_we       = accept && (in_item.func == dmm_pkg::FUNC_LOAD_B);
  assign slot_free  = !out_valid || !out_stall;
  assign entry_last = (n + CNT_W'(1)) == total;
  assign size_prod  = {{DIM_W{1'b0}}, eff_dim(a_rows)} * {{DIM_W{1'b0}}, eff_dim(b_cols)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    mac_ctl    = '0;
    emit       = 1'b0;
    emit_err   = 1'b0;
    start_ok   = 1'b0;
    take       = 1'b0;
    unique case (state)
      dmm_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (in_item.func == dmm_pkg::FUNC_START)) begin
          if (a_inner != b_rows) begin
            state_next = dmm_pkg::S_ERR;
          end else begin
            start_ok   = 1'b1;
            state_next = dmm_pkg::S_ISSUE;
          end
        end
      end
      dmm_pkg::S_ISSUE: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.first = (k == '0);
        mac_ctl.last  = (k == kdim - DIM_W'(1));
        if (mac_ctl.last) begin
          state_next = dmm_pkg::S_WAIT;
        end
      end
      dmm_pkg::S_WAIT: begin
        if (res_valid && slot_free) begin
          emit       = 1'b1;
          take       = 1'b1;
          state_next = entry_last ? dmm_pkg::S_IDLE : dmm_pkg::S_ISSUE;
        end
      end
      dmm_pkg::S_ERR: begin
        if (slot_free) begin
          emit_err   = 1'b1;
          state_next = dmm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dmm_pkg::S_IDLE;
      end
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows  <= DIM_W'(1);
      a_inner <= DIM_W'(1);
      b_rows  <= DIM_W'(1);
      b_cols  <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        dmm_pkg::CFG_A_ROWS:  a_rows  <= cfg_data;
        dmm_pkg::CFG_A_INNER: a_inner <= cfg_data;
        dmm_pkg::CFG_B_ROWS:  b_rows  <= cfg_data;
        dmm_pkg::CFG_B_COLS:  b_cols  <= cfg_data;
        default: ;
      endcase
    end
  end

  // loop counters and read addresses
  always_ff @(posedge clk) begin
    if (start_ok) begin
      kdim    <= eff_dim(a_inner);
      cols    <= eff_dim(b_cols);
      total   <= (size_prod > RESULT_CAP) ? dmm_pkg::MAX_RESULTS : size_prod[CNT_W-1:0];
      r       <= '0;
      s       <= '0;
      k       <= '0;
      n       <= '0;
      a_base  <= '0;
      a_raddr <= '0;
      b_raddr <= '0;
    end else if (mac_ctl.issue && !mac_ctl.last) begin
      k       <= k + DIM_W'(1);
      a_raddr <= a_raddr + ADDR_W'(1);
      b_raddr <= b_raddr + ADDR_W'(cols);
    end else if (emit && !entry_last) begin
      k <= '0;
      n <= n + CNT_W'(1);
      if (s == cols - DIM_W'(1)) begin
        s       <= '0;
        r       <= r + DIM_W'(1);
        a_base  <= a_base + ADDR_W'(kdim);
        a_raddr <= a_base + ADDR_W'(kdim);
        b_raddr <= '0;
      end else begin
        s       <= s + DIM_W'(1);
        a_raddr <= a_base;
        b_raddr <= ADDR_W'(s) + ADDR_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit || emit_err) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.prod_value    <= res_value;
      out_item.out_row       <= r[POS_W-1:0];
      out_item.out_col       <= s[POS_W-1:0];
      out_item.last          <= entry_last;
      out_item.size_mismatch <= 1'b0;
    end else if (emit_err) begin
      out_item.prod_value    <= '0;
      out_item.out_row       <= '0;
      out_item.out_col       <= '0;
      out_item.last          <= 1'b1;
      out_item.size_mismatch <= 1'b1;
    end
  end

  `ASSERT_CLK(a_result_only_in_wait, res_valid |-> state == dmm_pkg::S_WAIT, "stray mac result")
  `ASSERT_CLK(a_k_in_range, state == dmm_pkg::S_ISSUE |-> k < kdim && n < total, "counter overrun")
  `ASSERT_CLK(a_err_is_last, out_valid && out_item.size_mismatch |-> out_item.last, "error not last")

endmodule

// File: hdl/dense_matrix_multiply_core.sv
// a load item is taken while in_stall is low and gives no result
// a start gives its C entries one after another; each takes kdim reads, multiply, accumulate
// and hand-off to the output register before the next entry is issued
// a size mismatch item passes through S_ERR to the output register; input stalls while a start runs
// throughput is set by the single multiply-accumulate unit and one read port per store
// reset: sizes return to 1 and control clears; the element stores are not cleared
// ----------------------------------------------------------------------------
// dense_matrix_multiply_core
// Q16.16 dense matrix multiply over two element stores
// ----------------------------------------------------------------------------
module dense_matrix_multiply_core #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dmm_pkg::in_t                  in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dmm_pkg::out_t                 out_item,
  input  logic                          cfg_we,
  input  logic [dmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmm_pkg::DIM_W-1:0]     cfg_data
);

  logic                              a_we, b_we;
  logic [dmm_pkg::ADDR_W-1:0]        a_raddr, b_raddr;
  logic [dmm_pkg::DATA_W-1:0]        a_rdata, b_rdata;
  dmm_pkg::mac_ctl_t                 mac_ctl;
  logic                              take;
  logic                              res_valid;
  logic signed [dmm_pkg::DATA_W-1:0] res_value;

  dmm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .a_we      (a_we),
    .b_we      (b_we),
    .a_raddr   (a_raddr),
    .b_raddr   (b_raddr),
    .mac_ctl   (mac_ctl),
    .take      (take),
    .res_valid (res_valid),
    .res_value (res_value)
  );

  dmm_store u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (in_item.elem_index),
    .wdata (in_item.elem_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  dmm_store u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (in_item.elem_index),
    .wdata (in_item.elem_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  dmm_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mac_ctl),
    .a_data    (a_rdata),
    .b_data    (b_rdata),
    .take      (take),
    .res_valid (res_valid),
    .res_value (res_value)
  );

endmodule
